// File: hw/rtl/x86_16bit_instruction_decoder_top_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef X86_16BIT_INSTRUCTION_DECODER_TOP_MACROS_SVH
`define X86_16BIT_INSTRUCTION_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define X86D_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define X86D_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/x86d_pkg.sv
package x86d_pkg;

    // Instruction classes found from the opcode byte.
    typedef enum logic [2:0] {
        CLS_UNKNOWN,
        CLS_JUMP,
        CLS_MOV_IMM_REG,
        CLS_ACC_MEM,
        CLS_ACC_IMM,
        CLS_RM_REG,
        CLS_IMM_RM,
        CLS_SIGN_BYTE
    } cls_t;

    // Operation codes.
    localparam logic [4:0] OP_MOV = 5'd0;
    localparam logic [4:0] OP_ADD = 5'd1;
    localparam logic [4:0] OP_SUB = 5'd2;
    localparam logic [4:0] OP_CMP = 5'd3;
    localparam logic [4:0] OP_JZ     = 5'd4;
    localparam logic [4:0] OP_JL     = 5'd5;
    localparam logic [4:0] OP_JLE    = 5'd6;
    localparam logic [4:0] OP_JB     = 5'd7;
    localparam logic [4:0] OP_JBE    = 5'd8;
    localparam logic [4:0] OP_JP     = 5'd9;
    localparam logic [4:0] OP_JO     = 5'd10;
    localparam logic [4:0] OP_JS     = 5'd11;
    localparam logic [4:0] OP_JNZ    = 5'd12;
    localparam logic [4:0] OP_JNL    = 5'd13;
    localparam logic [4:0] OP_JNLE   = 5'd14;
    localparam logic [4:0] OP_JNB    = 5'd15;
    localparam logic [4:0] OP_JNBE   = 5'd16;
    localparam logic [4:0] OP_JNP    = 5'd17;
    localparam logic [4:0] OP_JNO    = 5'd18;
    localparam logic [4:0] OP_JNS    = 5'd19;
    localparam logic [4:0] OP_LOOP   = 5'd20;
    localparam logic [4:0] OP_LOOPZ  = 5'd21;
    localparam logic [4:0] OP_LOOPNZ = 5'd22;
    localparam logic [4:0] OP_JCXZ   = 5'd23;

    // Operand kinds.
    localparam logic [2:0] KIND_REG  = 3'd0;
    localparam logic [2:0] KIND_MEM  = 3'd1;
    localparam logic [2:0] KIND_IMM  = 3'd2;
    localparam logic [2:0] KIND_REL  = 3'd3;
    localparam logic [2:0] KIND_NONE = 3'd4;

    // Register portions.
    localparam logic [1:0] PART_LOW  = 2'd0;
    localparam logic [1:0] PART_WORD = 2'd2;

    // Address form used for a direct address.
    localparam logic [3:0] SEL_DIRECT = 4'd8;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_FORM    = 2'd2;

    // Opcode patterns.
    localparam logic [3:0] OPH_JCC     = 4'h7;
    localparam logic [5:0] OPH_LOOP    = 6'h38;
    localparam logic [3:0] OPH_MOV_IMM = 4'hB;
    localparam logic [5:0] OPH_ACC_MEM = 6'h28;
    localparam logic [6:0] OPH_ADD_AI  = 7'h02;
    localparam logic [6:0] OPH_SUB_AI  = 7'h16;
    localparam logic [6:0] OPH_CMP_AI  = 7'h1E;
    localparam logic [5:0] OPH_MOV_RM  = 6'h22;
    localparam logic [5:0] OPH_ADD_RM  = 6'h00;
    localparam logic [5:0] OPH_SUB_RM  = 6'h0A;
    localparam logic [5:0] OPH_CMP_RM  = 6'h0E;
    localparam logic [6:0] OPH_MOV_IRM = 7'h63;
    localparam logic [7:0] OPC_SX_BYTE = 8'h82;
    localparam logic [5:0] OPH_GRP_IRM = 6'h20;

    // Group extension codes in the reg field.
    localparam logic [2:0] EXT_ADD = 3'd0;
    localparam logic [2:0] EXT_SUB = 3'd5;
    localparam logic [2:0] EXT_CMP = 3'd7;

    // Buffer and length limits.
    localparam int BUF_DEPTH = 5;
    localparam int MAX_LEN   = 6;
    localparam logic [2:0] LAST_SLOT = 3'd5;

    // Register index from the encoding to register number a,b,c,d,sp,bp,si,di.
    localparam logic [3:0] WORD_REG_MAP [8] = '{
        4'd0, 4'd2, 4'd3, 4'd1, 4'd4, 4'd5, 4'd6, 4'd7
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  sel;
        logic [1:0]  part;
        logic [15:0] val;
    } opnd_t;

    // One assembled instruction passed from the front to the back.
    typedef struct packed {
        logic [MAX_LEN-1:0][7:0] bytes;
        logic [2:0]              len;
        logic [1:0]              err;
        cls_t                    cls;
    } instr_rec_t;

    // One decoded result.
    typedef struct packed {
        logic [4:0] op_kind;
        logic       is_word;
        logic [2:0] instr_length;
        opnd_t      dst;
        opnd_t      src;
        logic [1:0] decode_error;
    } result_t;

    function automatic cls_t classify(input logic [7:0] op);
        cls_t c;
        c = CLS_UNKNOWN;
        if (op[7:4] == OPH_JCC || op[7:2] == OPH_LOOP)
            c = CLS_JUMP;
        else if (op[7:4] == OPH_MOV_IMM)
            c = CLS_MOV_IMM_REG;
        else if (op[7:2] == OPH_ACC_MEM)
            c = CLS_ACC_MEM;
        else if (op[7:1] == OPH_ADD_AI || op[7:1] == OPH_SUB_AI || op[7:1] == OPH_CMP_AI)
            c = CLS_ACC_IMM;
        else if (op[7:2] == OPH_MOV_RM || op[7:2] == OPH_ADD_RM ||
                 op[7:2] == OPH_SUB_RM || op[7:2] == OPH_CMP_RM)
            c = CLS_RM_REG;
        else if (op[7:1] == OPH_MOV_IRM)
            c = CLS_IMM_RM;
        else if (op == OPC_SX_BYTE)
            c = CLS_SIGN_BYTE;
        else if (op[7:2] == OPH_GRP_IRM)
            c = CLS_IMM_RM;
        return c;
    endfunction

    // Operation code of a conditional jump or loop opcode.
    function automatic logic [4:0] jump_kind(input logic [7:0] op);
        logic [4:0] k;
        unique case (op)
            8'h74:   k = OP_JZ;
            8'h7C:   k = OP_JL;
            8'h7E:   k = OP_JLE;
            8'h72:   k = OP_JB;
            8'h76:   k = OP_JBE;
            8'h7A:   k = OP_JP;
            8'h70:   k = OP_JO;
            8'h78:   k = OP_JS;
            8'h75:   k = OP_JNZ;
            8'h7D:   k = OP_JNL;
            8'h7F:   k = OP_JNLE;
            8'h73:   k = OP_JNB;
            8'h77:   k = OP_JNBE;
            8'h7B:   k = OP_JNP;
            8'h71:   k = OP_JNO;
            8'h79:   k = OP_JNS;
            8'hE2:   k = OP_LOOP;
            8'hE1:   k = OP_LOOPZ;
            8'hE0:   k = OP_LOOPNZ;
            8'hE3:   k = OP_JCXZ;
            default: k = OP_MOV;
        endcase
        return k;
    endfunction

    // Arithmetic operation selected by a group or accumulator field.
    function automatic logic [4:0] arith_kind(input logic [2:0] f);
        logic [4:0] k;
        unique case (f)
            EXT_ADD: k = OP_ADD;
            EXT_SUB: k = OP_SUB;
            EXT_CMP: k = OP_CMP;
            default: k = OP_MOV;
        endcase
        return k;
    endfunction

    // A group opcode with a reg field other than add, sub or cmp is rejected.
    function automatic logic group_bad(input logic [7:0] op, input logic [7:0] modrm);
        logic [2:0] r;
        r = modrm[5:3];
        return (op[7:1] != OPH_MOV_IRM) && !(r == EXT_ADD || r == EXT_SUB || r == EXT_CMP);
    endfunction

    function automatic logic [1:0] disp_size(input logic [1:0] md, input logic [2:0] rm);
        logic [1:0] n;
        if (md == 2'd2 || (md == 2'd0 && rm == 3'd6))
            n = 2'd2;
        else if (md == 2'd1)
            n = 2'd1;
        else
            n = 2'd0;
        return n;
    endfunction

    // Length known from the opcode byte alone.
    function automatic logic [2:0] first_needed(input logic [7:0] op);
        logic [2:0] n;
        unique case (classify(op))
            CLS_MOV_IMM_REG: n = 3'd2 + {2'b00, op[3]};
            CLS_ACC_MEM:     n = 3'd3;
            CLS_ACC_IMM:     n = 3'd2 + {2'b00, op[0]};
            default:         n = 3'd2;
        endcase
        return n;
    endfunction

    // Length once the mod/reg/rm byte is known.
    function automatic logic [2:0] full_length(input logic [7:0] op, input logic [7:0] modrm);
        logic [2:0] n;
        logic       s;
        n = 3'd2 + {1'b0, disp_size(modrm[7:6], modrm[2:0])};
        if (classify(op) == CLS_IMM_RM) begin
            s = op[1] && (op[7:1] != OPH_MOV_IRM);
            n = n + ((s || !op[0]) ? 3'd1 : 3'd2);
        end
        return n;
    endfunction

    function automatic logic [15:0] sx8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    function automatic opnd_t none_op();
        opnd_t o;
        o.kind = KIND_NONE;
        o.sel  = 4'd0;
        o.part = PART_LOW;
        o.val  = 16'd0;
        return o;
    endfunction

    function automatic opnd_t reg_op(input logic [2:0] idx, input logic w);
        opnd_t o;
        o = none_op();
        o.kind = KIND_REG;
        if (w) begin
            o.sel  = WORD_REG_MAP[idx];
            o.part = PART_WORD;
        end
        else begin
            o.sel  = WORD_REG_MAP[{1'b0, idx[1:0]}];
            o.part = {1'b0, idx[2]};
        end
        return o;
    endfunction

    function automatic opnd_t mem_op(input logic [1:0] md, input logic [2:0] rm,
                                     input logic [7:0] p0, input logic [7:0] p1);
        opnd_t o;
        o = none_op();
        o.kind = KIND_MEM;
        o.sel  = {1'b0, rm};
        if (md == 2'd0 && rm == 3'd6)
            o.sel = SEL_DIRECT;
        if (disp_size(md, rm) == 2'd2)
            o.val = {p1, p0};
        else if (md == 2'd1)
            o.val = sx8(p0);
        return o;
    endfunction

    function automatic opnd_t imm_op(input logic [15:0] v);
        opnd_t o;
        o = none_op();
        o.kind = KIND_IMM;
        o.val  = v;
        return o;
    endfunction

endpackage

// File: hw/rtl/x86d_front.sv
`include "x86_16bit_instruction_decoder_top_macros.svh"

module x86d_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            code_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output x86d_pkg::instr_rec_t  q_rec
);

    logic [7:0]      buf_reg [x86d_pkg::BUF_DEPTH];
    logic [2:0]      taken_reg;
    logic [2:0]      taken_next;
    logic [2:0]      needed_reg;
    logic [2:0]      needed_next;
    logic            accept;
    logic            store;
    x86d_pkg::cls_t  cls_in;
    x86d_pkg::cls_t  cls_op;
    logic [2:0]      needed_eff;
    logic            first_rm;

    // Any completed instruction needs a queue slot, so stall while it is full.
    assign full   = q_full;
    assign accept = push && !q_full;
    assign cls_in = x86d_pkg::classify(code_byte);
    assign cls_op = x86d_pkg::classify(buf_reg[0]);
    assign first_rm = (taken_reg == 3'd1) &&
                      (cls_op == x86d_pkg::CLS_RM_REG || cls_op == x86d_pkg::CLS_IMM_RM);
    assign needed_eff = first_rm ? x86d_pkg::full_length(buf_reg[0], code_byte) : needed_reg;

    // Assemble the instruction bytes, with the arriving byte at its position, track
    // progress through the instruction and decide when it is complete.
    always_comb
    begin
        for (int i = 0; i < x86d_pkg::MAX_LEN; i++) begin
            if (3'(i) == taken_reg)
                q_rec.bytes[3'(i)] = code_byte;
            else if (i < x86d_pkg::BUF_DEPTH && 3'(i) < taken_reg)
                q_rec.bytes[3'(i)] = buf_reg[(i < x86d_pkg::BUF_DEPTH) ? 3'(i) : 3'd0];
            else
                q_rec.bytes[3'(i)] = 8'h00;
        end
        taken_next  = taken_reg;
        needed_next = needed_reg;
        q_push      = 1'b0;
        store       = 1'b0;
        q_rec.len   = taken_reg + 3'd1;
        q_rec.err   = x86d_pkg::ERR_NONE;
        q_rec.cls   = cls_op;
        if (accept) begin
            if (taken_reg == 3'd0) begin
                q_rec.cls = cls_in;
                if (cls_in == x86d_pkg::CLS_UNKNOWN || cls_in == x86d_pkg::CLS_SIGN_BYTE) begin
                    q_push    = 1'b1;
                    q_rec.err = (cls_in == x86d_pkg::CLS_UNKNOWN) ?
                                x86d_pkg::ERR_UNKNOWN : x86d_pkg::ERR_FORM;
                end
                else begin
                    store       = 1'b1;
                    taken_next  = 3'd1;
                    needed_next = x86d_pkg::first_needed(code_byte);
                end
            end
            else if (taken_reg == 3'd1 && cls_op == x86d_pkg::CLS_IMM_RM &&
                     x86d_pkg::group_bad(buf_reg[0], code_byte)) begin
                q_push      = 1'b1;
                q_rec.err   = x86d_pkg::ERR_FORM;
                taken_next  = 3'd0;
                needed_next = 3'd0;
            end
            else if (({1'b0, taken_reg} + 4'd1 >= {1'b0, needed_eff}) ||
                     taken_reg >= x86d_pkg::LAST_SLOT) begin
                q_push      = 1'b1;
                taken_next  = 3'd0;
                needed_next = 3'd0;
            end
            else begin
                store       = 1'b1;
                taken_next  = taken_reg + 3'd1;
                needed_next = needed_eff;
            end
        end
    end

    // Counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            taken_reg  <= 3'd0;
            needed_reg <= 3'd0;
        end
        else begin
            taken_reg  <= taken_next;
            needed_reg <= needed_next;
        end
    end

    // Byte buffer, written at the current position.
    always_ff @(posedge clk)
    begin
        if (store)
            buf_reg[taken_reg] <= code_byte;
    end

    `X86D_ASSERT_SAME(a_taken_range, clk, rst_n, 1'b1, taken_reg <= x86d_pkg::LAST_SLOT,
        "byte count beyond the buffer")
    `X86D_ASSERT_SAME(a_needed_set, clk, rst_n, taken_reg != 3'd0, needed_reg >= 3'd2,
        "partial instruction without a length")
    `X86D_ASSERT_NEXT(a_restart, clk, rst_n, q_push, taken_reg == 3'd0,
        "decoding did not restart after a finished instruction")

endmodule

// File: hw/rtl/x86d_queue.sv
`include "x86_16bit_instruction_decoder_top_macros.svh"

module x86d_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  x86d_pkg::instr_rec_t  wr_rec,
    output logic                  q_full,
    input  logic                  rd_en,
    output logic                  rd_valid,
    output x86d_pkg::instr_rec_t  rd_rec
);

    x86d_pkg::instr_rec_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_full   = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    `X86D_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= 2'd2,
        "queue count beyond its depth")
    `X86D_ASSERT_SAME(a_no_overflow, clk, rst_n, wr_en, !q_full,
        "write into a full queue")
    `X86D_ASSERT_SAME(a_no_underflow, clk, rst_n, rd_en, rd_valid,
        "read from an empty queue")

endmodule

// File: hw/rtl/x86d_back.sv
module x86d_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_valid,
    input  x86d_pkg::instr_rec_t  rd_rec,
    output logic                  rd_en,
    input  logic                  pop,
    output logic                  empty,
    output x86d_pkg::result_t     res
);

    x86d_pkg::result_t res_reg;
    x86d_pkg::result_t dec;
    logic              out_valid_reg;
    logic [7:0]        op;
    logic [7:0]        m;
    logic [1:0]        md;
    logic [2:0]        rm;
    logic [2:0]        pidx;
    logic [7:0]        p0;
    logic [7:0]        p1;
    logic              w;
    logic              sx;
    x86d_pkg::opnd_t   tmp;

    assign op = rd_rec.bytes[0];
    assign m  = rd_rec.bytes[1];
    assign md = m[7:6];
    assign rm = m[2:0];

    // Position of the immediate after the mod/reg/rm byte and displacement.
    assign pidx = 3'd2 + ((md == 2'd3) ? 3'd0 : {1'b0, x86d_pkg::disp_size(md, rm)});
    assign p0   = rd_rec.bytes[pidx];
    assign p1   = rd_rec.bytes[pidx + 3'd1];

    // Field decode of one assembled instruction.
    always_comb
    begin
        w   = op[0];
        sx  = 1'b0;
        tmp = x86d_pkg::none_op();
        dec.op_kind      = x86d_pkg::OP_MOV;
        dec.is_word      = 1'b0;
        dec.instr_length = rd_rec.len;
        dec.dst          = x86d_pkg::none_op();
        dec.src          = x86d_pkg::none_op();
        dec.decode_error = rd_rec.err;
        if (rd_rec.err == x86d_pkg::ERR_NONE) begin
            unique case (rd_rec.cls)
                x86d_pkg::CLS_JUMP: begin
                    w = 1'b0;
                    dec.op_kind  = x86d_pkg::jump_kind(op);
                    dec.dst.kind = x86d_pkg::KIND_REL;
                    dec.dst.val  = x86d_pkg::sx8(m);
                end
                x86d_pkg::CLS_MOV_IMM_REG: begin
                    w = op[3];
                    dec.dst = x86d_pkg::reg_op(op[2:0], w);
                    dec.src = x86d_pkg::imm_op(w ? {rd_rec.bytes[2], m} : {8'h00, m});
                end
                x86d_pkg::CLS_ACC_MEM: begin
                    dec.dst = x86d_pkg::reg_op(3'd0, w);
                    dec.src = x86d_pkg::mem_op(2'd0, 3'd6, m, rd_rec.bytes[2]);
                    if (op[1]) begin
                        tmp     = dec.dst;
                        dec.dst = dec.src;
                        dec.src = tmp;
                    end
                end
                x86d_pkg::CLS_ACC_IMM: begin
                    dec.op_kind = x86d_pkg::arith_kind(op[5:3]);
                    dec.dst = x86d_pkg::reg_op(3'd0, w);
                    dec.src = x86d_pkg::imm_op(w ? {rd_rec.bytes[2], m} : {8'h00, m});
                end
                x86d_pkg::CLS_RM_REG: begin
                    dec.dst = (md == 2'd3) ? x86d_pkg::reg_op(rm, w) :
                              x86d_pkg::mem_op(md, rm, rd_rec.bytes[2], rd_rec.bytes[3]);
                    unique case (op[7:2])
                        x86d_pkg::OPH_MOV_RM: dec.op_kind = x86d_pkg::OP_MOV;
                        x86d_pkg::OPH_ADD_RM: dec.op_kind = x86d_pkg::OP_ADD;
                        x86d_pkg::OPH_SUB_RM: dec.op_kind = x86d_pkg::OP_SUB;
                        default:              dec.op_kind = x86d_pkg::OP_CMP;
                    endcase
                    dec.src = x86d_pkg::reg_op(m[5:3], w);
                    if (op[1]) begin
                        tmp     = dec.dst;
                        dec.dst = dec.src;
                        dec.src = tmp;
                    end
                end
                x86d_pkg::CLS_IMM_RM: begin
                    dec.dst = (md == 2'd3) ? x86d_pkg::reg_op(rm, w) :
                              x86d_pkg::mem_op(md, rm, rd_rec.bytes[2], rd_rec.bytes[3]);
                    if (op[7:1] == x86d_pkg::OPH_MOV_IRM) begin
                        dec.op_kind = x86d_pkg::OP_MOV;
                        sx = 1'b0;
                    end
                    else begin
                        dec.op_kind = x86d_pkg::arith_kind(m[5:3]);
                        sx = op[1];
                    end
                    if (sx)
                        dec.src = x86d_pkg::imm_op(x86d_pkg::sx8(p0));
                    else
                        dec.src = x86d_pkg::imm_op(w ? {p1, p0} : {8'h00, p0});
                end
                default: begin
                    w = 1'b0;
                end
            endcase
            dec.is_word = w;
        end
    end

    // The result register refills whenever an entry waits and it is free or being taken.
    assign rd_en = rd_valid && (!out_valid_reg || pop);
    assign empty = !out_valid_reg;
    assign res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rd_en)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            res_reg <= dec;
    end

endmodule

// File: hw/rtl/x86_16bit_instruction_decoder_top.sv
// Byte-serial decoder for a subset of 8086 instructions.
// Input channel: code_byte is transferred when push is high and full is low,
// one byte of the code stream per transfer, in fetch order.
// Result channel: while empty is low the oldest decoded instruction is on the
// result ports; it is transferred when pop is high and empty is low.
// Each finished instruction (or rejected opcode) gives exactly one result.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// The front writes a finished instruction into the queue at the transfer of
// its last byte; the result register loads it once it is the oldest entry
// and the register is free or being taken.
// A two-entry queue sits between the byte assembler and the field decoder;
// when the receiver stalls, the result register and the queue fill, and then
// full rises and input stops.
// Reset clears the byte count, the queue's count and pointers and the result
// valid flag; decoding starts at the next byte with no pending instruction.
module x86_16bit_instruction_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  code_byte,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  op_kind,
    output logic        is_word,
    output logic [2:0]  instr_length,
    output logic [2:0]  dst_kind,
    output logic [3:0]  dst_select,
    output logic [1:0]  dst_part,
    output logic [15:0] dst_value,
    output logic [2:0]  src_kind,
    output logic [3:0]  src_select,
    output logic [1:0]  src_part,
    output logic [15:0] src_data,
    output logic [1:0]  decode_error
);

    logic                  q_full;
    logic                  q_push;
    x86d_pkg::instr_rec_t  q_rec;
    logic                  rd_en;
    logic                  rd_valid;
    x86d_pkg::instr_rec_t  rd_rec;
    x86d_pkg::result_t     res;

    x86d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .code_byte (code_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (q_rec)
    );

    x86d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_rec   (q_rec),
        .q_full   (q_full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_rec   (rd_rec)
    );

    x86d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_rec   (rd_rec),
        .rd_en    (rd_en),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

    // Result fields.
    assign op_kind      = res.op_kind;
    assign is_word      = res.is_word;
    assign instr_length = res.instr_length;
    assign dst_kind     = res.dst.kind;
    assign dst_select   = res.dst.sel;
    assign dst_part     = res.dst.part;
    assign dst_value    = res.dst.val;
    assign src_kind     = res.src.kind;
    assign src_select   = res.src.sel;
    assign src_part     = res.src.part;
    assign src_data     = res.src.val;
    assign decode_error = res.decode_error;

endmodule
